// ----- src/iimdf_pkg.sv -----
// Shared types, codes and tag tables for the dataset deframer.
// Used by iimdf_front, iimdf_queue, iimdf_back and iim_dataset_deframer.
package iimdf_pkg;

   localparam logic [7:0] MARKER_BYTE = 8'h1c;
   localparam logic [7:0] REC_ENV     = 8'h01;
   localparam logic [7:0] REC_APP     = 8'h02;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;
   localparam logic [1:0] KIND_TRUNC   = 2'd3;

   localparam int QUEUE_DEPTH = 4;

   // one classified result waiting for the back end
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       is_app;
      logic [7:0] tag;
      logic       last;
   } entry_type;

   // {known, repeatable} for a tag of the envelope record
   function automatic logic [1:0] env_lookup(input logic [7:0] tag);
      logic [1:0] res;
      res = 2'b00;
      unique case (tag)
         8'd5, 8'd50: res = 2'b11;
         8'd0, 8'd20, 8'd22, 8'd30, 8'd40, 8'd60, 8'd70, 8'd80, 8'd90,
         8'd100, 8'd120, 8'd122: res = 2'b10;
         default: res = 2'b00;
      endcase
      return res;
   endfunction

   // {known, repeatable} for a tag of the application record
   function automatic logic [1:0] app_lookup(input logic [7:0] tag);
      logic [1:0] res;
      res = 2'b00;
      unique case (tag)
         8'd4, 8'd12, 8'd20, 8'd25, 8'd26, 8'd27, 8'd45, 8'd50, 8'd80,
         8'd85: res = 2'b11;
         8'd0, 8'd3, 8'd5, 8'd7, 8'd10, 8'd15, 8'd22, 8'd30, 8'd35, 8'd37,
         8'd38, 8'd40, 8'd47, 8'd55, 8'd60, 8'd62, 8'd63, 8'd65, 8'd70,
         8'd90, 8'd92, 8'd95, 8'd100, 8'd101, 8'd103, 8'd105, 8'd110,
         8'd115, 8'd116, 8'd118, 8'd120, 8'd121, 8'd122, 8'd184, 8'd185,
         8'd186, 8'd187, 8'd188, 8'd221, 8'd225, 8'd228, 8'd230,
         8'd231: res = 2'b10;
         default: res = 2'b00;
      endcase
      return res;
   endfunction

endpackage

// ----- src/iim_dataset_deframer.sv -----
// Dataset deframer for metadata segments: one byte per transaction in.
// Each result is written into the queue at the edge that accepts its byte
// and is loaded into the output register once that register is free.
// Throughput: one byte per cycle while the result queue has room.
// Input stalls only when the result queue fills behind a stalled output.
// Reset (synchronous, active high) empties the queue and output register
// and puts the parser in front of a marker byte, as at a segment start.
module iim_dataset_deframer #(
   parameter int QUEUE_DEPTH = iimdf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] segment_start
   input  logic        req_tlast,   // segment_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [8] record_is_app,
                                    // [16:9] tag_number, [17] known_tag,
                                    // [18] repeatable_tag, [23:19] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_dataset
);

   logic                 q_full, q_empty, q_push, q_pop, take;
   iimdf_pkg::entry_type q_in, q_head;

   // Accept a byte whenever the queue has room; every byte yields at most
   // one result, so one free slot is always enough.
   assign req_tready = !q_full;
   assign take       = req_tvalid & req_tready;

   // Classify the byte and advance the framing state.
   iimdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_tdata),
      .seg_start  (req_tuser),
      .seg_end    (req_tlast),
      .push       (q_push),
      .push_entry (q_in)
   );

   // Decouple the parser from output backpressure.
   iimdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (q_head)
   );

   // Look up the tag flags and drive the result register.
   iimdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/iimdf_front.sv -----
// Front end: tracks dataset framing and classifies each input byte.
// Depends on iimdf_pkg; pushes results into iimdf_queue.
module iimdf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           in_byte,
   input  logic                 seg_start,
   input  logic                 seg_end,
   output logic                 push,
   output iimdf_pkg::entry_type push_entry
);

   localparam logic [2:0] PH_MARK = 3'd0;
   localparam logic [2:0] PH_REC  = 3'd1;
   localparam logic [2:0] PH_TAG  = 3'd2;
   localparam logic [2:0] PH_LHI  = 3'd3;
   localparam logic [2:0] PH_LLO  = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_IDLE = 3'd6;

   logic [2:0]  phase_ff, phase_in, ph_cur;
   logic        rec_ff, rec_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] left_ff, left_in;
   logic        res;
   iimdf_pkg::entry_type ent;

   always_comb begin
      ph_cur   = seg_start ? PH_MARK : phase_ff;
      phase_in = ph_cur;
      rec_in   = rec_ff;
      tag_in   = tag_ff;
      left_in  = left_ff;
      res      = 1'b0;
      ent      = '0;
      unique case (ph_cur)
         PH_MARK: begin
            if (in_byte == iimdf_pkg::MARKER_BYTE) begin
               phase_in = PH_REC;
            end else begin
               res      = 1'b1;
               ent.kind = iimdf_pkg::KIND_BAD;
               phase_in = PH_IDLE;
            end
         end
         PH_REC: begin
            if (in_byte == iimdf_pkg::REC_APP || in_byte == iimdf_pkg::REC_ENV) begin
               rec_in   = (in_byte == iimdf_pkg::REC_APP);
               phase_in = PH_TAG;
            end else begin
               res      = 1'b1;
               ent.kind = iimdf_pkg::KIND_BAD;
               phase_in = PH_IDLE;
            end
         end
         PH_TAG: begin
            tag_in   = in_byte;
            phase_in = PH_LHI;
         end
         PH_LHI: begin
            left_in  = {in_byte, 8'h00};
            phase_in = PH_LLO;
         end
         PH_LLO: begin
            left_in = {left_ff[15:8], in_byte};
            if ({left_ff[15:8], in_byte} == 16'd0) begin
               res        = 1'b1;
               ent.kind   = iimdf_pkg::KIND_EMPTY;
               ent.is_app = rec_ff;
               ent.tag    = tag_ff;
               phase_in   = PH_MARK;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            left_in    = left_ff - 16'd1;
            res        = 1'b1;
            ent.kind   = iimdf_pkg::KIND_PAYLOAD;
            ent.data   = in_byte;
            ent.is_app = rec_ff;
            ent.tag    = tag_ff;
            ent.last   = (left_ff == 16'd1);
            if (left_ff == 16'd1) begin
               phase_in = PH_MARK;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      // segment end inside a dataset replaces any result with truncated
      if (seg_end) begin
         if (phase_in >= PH_REC && phase_in <= PH_DATA) begin
            res      = 1'b1;
            ent      = '0;
            ent.kind = iimdf_pkg::KIND_TRUNC;
         end
         phase_in = PH_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MARK;
         rec_ff   <= 1'b0;
         tag_ff   <= 8'd0;
         left_ff  <= 16'd0;
      end else if (take) begin
         phase_ff <= phase_in;
         rec_ff   <= rec_in;
         tag_ff   <= tag_in;
         left_ff  <= left_in;
      end
   end

   assign push       = take & res;
   assign push_entry = ent;

endmodule

// ----- src/iimdf_queue.sv -----
// Short FIFO between the framing front end and the output back end.
// Depends on iimdf_pkg for the entry type.
module iimdf_queue #(
   parameter int DEPTH = iimdf_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  iimdf_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output iimdf_pkg::entry_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   iimdf_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   assign full  = (cnt_ff == FULL_CNT);
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ff];

endmodule

// ----- src/iimdf_back.sv -----
// Back end: looks up tag flags and holds the result in the output register.
// Depends on iimdf_pkg for the entry type and tag tables.
module iimdf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  iimdf_pkg::entry_type q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   logic                 valid_ff;
   iimdf_pkg::entry_type ent_ff;
   logic [1:0]           flags_ff, flags_in;
   logic                 with_tag;

   assign q_pop    = !q_empty && (!valid_ff || rsp_tready);
   assign with_tag = (q_head.kind == iimdf_pkg::KIND_PAYLOAD) ||
                     (q_head.kind == iimdf_pkg::KIND_EMPTY);

   always_comb begin
      flags_in = q_head.is_app ? iimdf_pkg::app_lookup(q_head.tag)
                               : iimdf_pkg::env_lookup(q_head.tag);
      if (!with_tag) begin
         flags_in = 2'b00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (q_pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_ff   <= q_head;
         flags_ff <= flags_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, flags_ff[0], flags_ff[1], ent_ff.tag, ent_ff.is_app,
                        ent_ff.data};
   assign rsp_tuser  = ent_ff.kind;
   assign rsp_tlast  = ent_ff.last;

endmodule

// ----- dv/iim_dataset_deframer_tb.sv -----
// Self-checking testbench for iim_dataset_deframer: streams segment bytes in,
// predicts each result with a local dataset parser and checks it field by field.
// Depends on iimdf_pkg and the iim_dataset_deframer RTL.
`timescale 1ns / 100ps

module iim_dataset_deframer_tb;

   localparam int QUIET_LIMIT = 2000;

   typedef enum logic [2:0] {
      P_MARKER, P_RECORD, P_TAG, P_LEN_HI, P_LEN_LO, P_PAYLOAD, P_IDLE
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       seg_start;
      logic       seg_end;
   } seg_byte_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       is_app;
      logic [7:0] tag;
      logic       known;
      logic       rep;
      logic       last;
   } dataset_result_type;

   // tag tables of the two records
   int env_tags[14] = '{0, 5, 20, 22, 30, 40, 50, 60, 70, 80, 90, 100, 120, 122};
   int env_rep_tags[2] = '{5, 50};
   int app_tags[53] = '{
      0, 3, 4, 5, 7, 10, 12, 15, 20, 22, 25, 26, 27, 30, 35, 37, 38, 40,
      45, 47, 50, 55, 60, 62, 63, 65, 70, 80, 85, 90, 92, 95, 100, 101,
      103, 105, 110, 115, 116, 118, 120, 121, 122, 184, 185, 186, 187, 188,
      221, 225, 228, 230, 231};
   int app_rep_tags[10] = '{4, 12, 20, 25, 26, 27, 45, 50, 80, 85};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   // parser state of the predictor
   parse_phase_type parse_phase = P_MARKER;
   logic            rec_is_app  = 1'b0;
   logic [7:0]      cur_tag     = '0;
   logic [15:0]     bytes_left  = '0;

   seg_byte_type       seg_bytes_q[$];
   dataset_result_type dataset_results_q[$];
   seg_byte_type       next_byte;
   dataset_result_type want;

   bit          req_taken = 1'b0;
   int unsigned req_idle_pct = 10;
   int unsigned rsp_idle_pct = 62;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   iim_dataset_deframer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // {known, repeatable} of a tag in the table of its record
   function automatic logic [1:0] tag_class(input logic app, input logic [7:0] tag);
      logic [1:0] f;
      f = 2'b00;
      if (app) begin
         foreach (app_tags[i]) if (app_tags[i] == tag) f[1] = 1'b1;
         foreach (app_rep_tags[i]) if (app_rep_tags[i] == tag) f[0] = 1'b1;
      end else begin
         foreach (env_tags[i]) if (env_tags[i] == tag) f[1] = 1'b1;
         foreach (env_rep_tags[i]) if (env_rep_tags[i] == tag) f[0] = 1'b1;
      end
      return f;
   endfunction

   function automatic dataset_result_type make_result(input logic [1:0] kind,
         input logic [7:0] data, input logic with_tag, input logic last);
      dataset_result_type r;
      logic [1:0]         f;
      r = '0;
      r.kind = kind;
      r.data = data;
      r.last = last;
      if (with_tag) begin
         f = tag_class(rec_is_app, cur_tag);
         r.is_app = rec_is_app;
         r.tag    = cur_tag;
         r.known  = f[1];
         r.rep    = f[0];
      end
      return r;
   endfunction

   // advance the parser by one accepted byte and queue the result it gives
   function automatic void parse_byte(input logic [7:0] b, input logic s, input logic e);
      dataset_result_type r;
      logic               hit;
      r = '0;
      hit = 1'b0;
      if (s) parse_phase = P_MARKER;
      case (parse_phase)
         P_MARKER: begin
            if (b == iimdf_pkg::MARKER_BYTE) begin
               parse_phase = P_RECORD;
            end else begin
               r = make_result(iimdf_pkg::KIND_BAD, 8'h00, 1'b0, 1'b0);
               hit = 1'b1;
               parse_phase = P_IDLE;
            end
         end
         P_RECORD: begin
            if (b == iimdf_pkg::REC_APP || b == iimdf_pkg::REC_ENV) begin
               rec_is_app = (b == iimdf_pkg::REC_APP);
               parse_phase = P_TAG;
            end else begin
               r = make_result(iimdf_pkg::KIND_BAD, 8'h00, 1'b0, 1'b0);
               hit = 1'b1;
               parse_phase = P_IDLE;
            end
         end
         P_TAG: begin
            cur_tag = b;
            parse_phase = P_LEN_HI;
         end
         P_LEN_HI: begin
            bytes_left = {b, 8'h00};
            parse_phase = P_LEN_LO;
         end
         P_LEN_LO: begin
            bytes_left[7:0] = b;
            if (bytes_left == 16'd0) begin
               r = make_result(iimdf_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b0);
               hit = 1'b1;
               parse_phase = P_MARKER;
            end else begin
               parse_phase = P_PAYLOAD;
            end
         end
         P_PAYLOAD: begin
            bytes_left = bytes_left - 16'd1;
            r = make_result(iimdf_pkg::KIND_PAYLOAD, b, 1'b1, bytes_left == 16'd0);
            hit = 1'b1;
            if (bytes_left == 16'd0) parse_phase = P_MARKER;
         end
         default: parse_phase = P_IDLE;
      endcase
      // segment end inside a dataset replaces any result with a truncation
      if (e) begin
         if (parse_phase != P_MARKER && parse_phase != P_IDLE) begin
            r = make_result(iimdf_pkg::KIND_TRUNC, 8'h00, 1'b0, 1'b0);
            hit = 1'b1;
         end
         parse_phase = P_IDLE;
      end
      if (hit) dataset_results_q.insert(dataset_results_q.size(), r);
   endfunction

   function automatic void queue_byte(input logic [7:0] b, input logic s, input logic e);
      seg_byte_type item;
      item.value     = b;
      item.seg_start = s;
      item.seg_end   = e;
      seg_bytes_q.insert(seg_bytes_q.size(), item);
   endfunction

   // one segment of random datasets; mostly well formed, some broken or cut
   task automatic add_segment(inout int made);
      int unsigned seg[$];
      int unsigned len;
      int unsigned cap;
      int          n_sets;
      int          roll;
      int          cut;
      int          k;
      bit          with_end;
      n_sets = $urandom_range(1, 4);
      for (k = 0; k < n_sets; k++) begin
         roll = $urandom_range(99);
         seg.insert(seg.size(), roll < 3 ? $urandom_range(255) : iimdf_pkg::MARKER_BYTE);
         roll = $urandom_range(99);
         seg.insert(seg.size(), roll < 4 ? $urandom_range(255) :
                    (roll < 52 ? iimdf_pkg::REC_APP : iimdf_pkg::REC_ENV));
         roll = $urandom_range(99);
         if (roll < 40) seg.insert(seg.size(), app_tags[$urandom_range(52)]);
         else if (roll < 60) seg.insert(seg.size(), env_tags[$urandom_range(13)]);
         else seg.insert(seg.size(), $urandom_range(255));
         roll = $urandom_range(99);
         if (roll < 70) len = $urandom_range(4);
         else if (roll < 92) len = $urandom_range(24, 5);
         else len = $urandom_range(16'hffff);
         seg.insert(seg.size(), len >> 8);
         seg.insert(seg.size(), len & 8'hff);
         // long lengths are never completed: the segment is cut inside them
         cap = (len > 40) ? $urandom_range(12) : len;
         repeat (cap) seg.insert(seg.size(), $urandom_range(255));
         if (cap < len) break;
      end
      roll = $urandom_range(99);
      if (roll < 20) begin
         cut = $urandom_range(seg.size() - 1);
         while (seg.size() > cut + 1) void'(seg.pop_back());
      end
      // without an end the next segment start restarts the parser mid-state
      with_end = (roll < 90);
      for (k = 0; k < seg.size(); k++)
         queue_byte(8'(seg[k]), k == 0, with_end && (k == seg.size() - 1));
      made += seg.size();
      // trailing noise after the end is ignored by the block
      if (with_end && $urandom_range(9) == 0)
         repeat ($urandom_range(3, 1))
            queue_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
   endtask

   // hold until every queued byte has gone in and every result has come out
   task automatic drain_results();
      while (seg_bytes_q.size() != 0 || req_tvalid || dataset_results_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want_v,
         input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         mismatches++;
      end
   endtask

   // driver: present the next byte at the falling edge once the last one is taken
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (seg_bytes_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
            next_byte = seg_bytes_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.value;
            req_tuser  <= next_byte.seg_start;
            req_tlast  <= next_byte.seg_end;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   // monitor: predict on each accepted byte, check each accepted result
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            parse_byte(req_tdata, req_tuser, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (dataset_results_q.size() == 0) begin
               $error("result with no transaction pending: kind %0d data %0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = dataset_results_q.pop_front();
               check_field("kind", 8'(want.kind), 8'(rsp_tuser));
               check_field("out_byte", want.data, rsp_tdata[7:0]);
               check_field("record_is_app", 8'(want.is_app), 8'(rsp_tdata[8]));
               check_field("tag_number", want.tag, rsp_tdata[16:9]);
               check_field("known_tag", 8'(want.known), 8'(rsp_tdata[17]));
               check_field("repeatable_tag", 8'(want.rep), 8'(rsp_tdata[18]));
               check_field("pad", 8'h00, 8'(rsp_tdata[23:19]));
               check_field("last_of_dataset", 8'(want.last), 8'(rsp_tlast));
            end
         end
         if (req_taken || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      int parsed;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no segment start after reset: application tag 25, one payload byte
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b0, 1'b0);
      queue_byte(iimdf_pkg::REC_APP, 1'b0, 1'b0);
      queue_byte(8'd25, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      // empty envelope dataset, tag 5; segment ends on the dataset boundary
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b0, 1'b0);
      queue_byte(iimdf_pkg::REC_ENV, 1'b0, 1'b0);
      queue_byte(8'd5, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b1);
      // ignored: no segment start after the end
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b0, 1'b0);
      // start and end on one byte with a bad marker
      queue_byte(8'h00, 1'b1, 1'b1);
      // bad record byte, then an ignored byte
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b1, 1'b0);
      queue_byte(8'h03, 1'b0, 1'b0);
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b0, 1'b1);
      // unknown tag 255, length 0xff00, cut after one payload byte
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b1, 1'b0);
      queue_byte(iimdf_pkg::REC_APP, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'hff, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b1);
      // segment of a lone marker: truncated
      queue_byte(iimdf_pkg::MARKER_BYTE, 1'b1, 1'b1);

      parsed = 0;
      while (parsed < 230) add_segment(parsed);
      drain_results();

      req_idle_pct = 62;
      rsp_idle_pct = 10;
      parsed = 0;
      while (parsed < 235) add_segment(parsed);
      drain_results();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      parsed = 0;
      while (parsed < 235) add_segment(parsed);
      drain_results();

      // let any stray result surface
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/iimdf_pkg.sv
src/iimdf_front.sv
src/iimdf_queue.sv
src/iimdf_back.sv
src/iim_dataset_deframer.sv
dv/iim_dataset_deframer_tb.sv
